@@ hw/rtl/rsb_pkg.sv @@
// Shared types and constants for the RGB saturation boost block.
package rsb_pkg;

    // Fixed field widths of the pixel channels and the gain register.
    localparam int PIXEL_BITS     = 8;
    localparam int GAIN_BITS      = 10;
    localparam int GAIN_FRAC_BITS = 8;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 10'd384;

    // Input pixel transaction.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] in_red;
        logic [PIXEL_BITS-1:0] in_green;
        logic [PIXEL_BITS-1:0] in_blue;
        logic                  in_last;
    } pixel_in_t;

    // Output pixel transaction.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] out_red;
        logic [PIXEL_BITS-1:0] out_green;
        logic [PIXEL_BITS-1:0] out_blue;
        logic [PIXEL_BITS-1:0] out_alpha;
        logic                  out_last;
    } pixel_out_t;

endpackage

@@ hw/rtl/rgb_saturation_boost.sv @@
// Top level of the RGB saturation boost pipeline.
//
//   Channel   Ports                          Direction  Contents
//   s_        s_valid, s_ready, s_data       in         pixel_in_t transaction
//   m_        m_valid, m_ready, m_data       out        pixel_out_t transaction
//   cfg_      cfg_wr_en, cfg_wr_data         in         saturation gain, Q2.8
//
// One transaction is accepted per clock while s_ready is high. A transaction passes
// four stages for extremes, difference, chroma and product, then one stage per
// quotient bit of the restoring divider, then the output register.
// Reset (synchronous, aresetn low) empties the pipeline and sets the gain to 1.5.
// Each stage holds its transaction while the stage after it is full and stalled,
// so bubbles close up and a stall loses or repeats nothing.
module rgb_saturation_boost #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  rsb_pkg::pixel_in_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output rsb_pkg::pixel_out_t                m_data,
    input  logic                               cfg_wr_en,
    input  logic [rsb_pkg::GAIN_BITS-1:0]      cfg_wr_data
);

    localparam int N    = CHANNEL_BITS;
    localparam int GW   = rsb_pkg::GAIN_BITS;
    localparam int PB   = rsb_pkg::PIXEL_BITS;
    localparam int NDIV = 4;
    localparam int S    = NDIV + N;
    localparam logic [PB-1:0] ALPHA = PB'((1 << N) - 1);

    // Payload carried through every internal stage.
    typedef struct packed {
        logic [N-1:0] red;
        logic [N-1:0] green;
        logic [N-1:0] blue;
        logic [N-1:0] mx;
        logic [N-1:0] mn;
        logic [N-1:0] delta;
        logic [N-1:0] mid_off;
        logic [N-1:0] c;
        logic [N-1:0] rem;
        logic [N-1:0] low;
        logic [N-1:0] quo;
        logic         last;
    } stage_t;

    logic [GW-1:0]       gain_reg;
    stage_t              st_reg  [S];
    stage_t              st_next [S];
    logic [S-1:0]        valid_reg;
    logic [S:0]          adv;
    logic                m_valid_reg;
    rsb_pkg::pixel_out_t m_data_reg;
    rsb_pkg::pixel_out_t m_data_next;

    // Gain register, written directly from the configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= rsb_pkg::GAIN_RESET;
        end else if (cfg_wr_en) begin
            gain_reg <= cfg_wr_data;
        end
    end

    // A stage may load when it is empty or its contents move on this cycle.
    assign adv[S] = !m_valid_reg || m_ready;
    generate
        for (genvar i = 0; i < S; i++) begin : g_adv
            assign adv[i] = !valid_reg[i] || adv[i+1];
        end
    endgenerate
    assign s_ready = adv[0];

    generate
        for (genvar i = 0; i < S; i++) begin : g_stage
            if (i == 0) begin : g_minmax
                logic [N-1:0] r;
                logic [N-1:0] g;
                logic [N-1:0] b;
                logic [N-1:0] mx_rg;
                logic [N-1:0] mn_rg;

                // Stage 0: take the channels and find the largest and smallest.
                assign r     = N'(s_data.in_red);
                assign g     = N'(s_data.in_green);
                assign b     = N'(s_data.in_blue);
                assign mx_rg = (g > r) ? g : r;
                assign mn_rg = (g < r) ? g : r;
                always_comb begin
                    st_next[i]       = '0;
                    st_next[i].red   = r;
                    st_next[i].green = g;
                    st_next[i].blue  = b;
                    st_next[i].mx    = (b > mx_rg) ? b : mx_rg;
                    st_next[i].mn    = (b < mn_rg) ? b : mn_rg;
                    st_next[i].last  = s_data.in_last;
                end
            end else if (i == 1) begin : g_delta
                logic [N+1:0] mid_sum;

                // Stage 1: the spread and the middle channel's offset above the minimum.
                assign mid_sum = (N+2)'(st_reg[i-1].red) + (N+2)'(st_reg[i-1].green)
                               + (N+2)'(st_reg[i-1].blue) - (N+2)'(st_reg[i-1].mx)
                               - (N+2)'(st_reg[i-1].mn);
                always_comb begin
                    st_next[i]         = st_reg[i-1];
                    st_next[i].delta   = st_reg[i-1].mx - st_reg[i-1].mn;
                    st_next[i].mid_off = N'(mid_sum) - st_reg[i-1].mn;
                end
            end else if (i == 2) begin : g_chroma
                logic [GW+N-1:0] prod;
                logic [GW+N-1:0] scaled;

                // Stage 2: new chroma from the gain, clamped at the value.
                assign prod   = (GW+N)'(gain_reg) * (GW+N)'(st_reg[i-1].delta);
                assign scaled = prod >> rsb_pkg::GAIN_FRAC_BITS;
                always_comb begin
                    st_next[i]   = st_reg[i-1];
                    st_next[i].c = (scaled > (GW+N)'(st_reg[i-1].mx)) ?
                                   st_reg[i-1].mx : N'(scaled);
                end
            end else if (i == 3) begin : g_product
                logic [2*N-1:0] num;

                // Stage 3: dividend for the middle channel, split for the divider.
                assign num = (2*N)'(st_reg[i-1].c) * (2*N)'(st_reg[i-1].mid_off);
                always_comb begin
                    st_next[i]     = st_reg[i-1];
                    st_next[i].rem = num[2*N-1:N];
                    st_next[i].low = num[N-1:0];
                    st_next[i].quo = '0;
                end
            end else begin : g_div
                logic [N:0] trial;
                logic       fits;

                // Divider stage: one restoring step, one quotient bit.
                assign trial = {st_reg[i-1].rem, st_reg[i-1].low[N-1]};
                assign fits  = (trial >= {1'b0, st_reg[i-1].delta});
                always_comb begin
                    st_next[i]     = st_reg[i-1];
                    st_next[i].rem = fits ? N'(trial - {1'b0, st_reg[i-1].delta})
                                          : N'(trial);
                    st_next[i].low = st_reg[i-1].low << 1;
                    st_next[i].quo = {st_reg[i-1].quo[N-2:0], fits};
                end
            end

            // Stage registers: valid is control, the payload needs no reset.
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[i] <= 1'b0;
                end else if (adv[i]) begin
                    if (i == 0) begin
                        valid_reg[i] <= s_valid;
                    end else begin
                        valid_reg[i] <= valid_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (adv[i]) begin
                    st_reg[i] <= st_next[i];
                end
            end
        end
    endgenerate

    // Largest channel keeps the value, smallest drops to the value less the chroma,
    // the middle one sits at its scaled position in between.
    function automatic logic [N-1:0] boost(input logic [N-1:0] ch,
                                           input logic [N-1:0] mx,
                                           input logic [N-1:0] mn,
                                           input logic [N-1:0] base,
                                           input logic [N-1:0] quo);
        logic [N-1:0] res;
        begin
            if (ch == mx) begin
                res = mx;
            end else if (ch == mn) begin
                res = base;
            end else begin
                res = base + quo;
            end
            return res;
        end
    endfunction

    // Output stage: assemble the result, gray pixels pass unchanged.
    always_comb begin
        logic [N-1:0] base;
        logic [N-1:0] red_o;
        logic [N-1:0] green_o;
        logic [N-1:0] blue_o;
        base = st_reg[S-1].mx - st_reg[S-1].c;
        if (st_reg[S-1].delta == '0) begin
            red_o   = st_reg[S-1].red;
            green_o = st_reg[S-1].green;
            blue_o  = st_reg[S-1].blue;
        end else begin
            red_o   = boost(st_reg[S-1].red, st_reg[S-1].mx, st_reg[S-1].mn,
                            base, st_reg[S-1].quo);
            green_o = boost(st_reg[S-1].green, st_reg[S-1].mx, st_reg[S-1].mn,
                            base, st_reg[S-1].quo);
            blue_o  = boost(st_reg[S-1].blue, st_reg[S-1].mx, st_reg[S-1].mn,
                            base, st_reg[S-1].quo);
        end
        m_data_next.out_red   = PB'(red_o);
        m_data_next.out_green = PB'(green_o);
        m_data_next.out_blue  = PB'(blue_o);
        m_data_next.out_alpha = ALPHA;
        m_data_next.out_last  = st_reg[S-1].last;
    end

    // Output register holds a transaction until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv[S]) begin
            m_valid_reg <= valid_reg[S-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[S]) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
